>>> hw/rtl/thbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thbr_pkg
// Shared constants and types of the threshold heartbeat rate detector.
// ----------------------------------------------------------------------------
package thbr_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int TIME_W    = 32;
	localparam int BPM_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP_MS     = 2'd1;

	localparam logic signed [SAMPLE_W-1:0] PEAK_THRESHOLD_RST = 16'sd2000;
	localparam logic [CFG_W-1:0]           MIN_GAP_MS_RST     = 16'd600;

	localparam logic [BPM_W-1:0] RATE_NUMERATOR = 16'd60000;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = 2;

	localparam int DIV_STEPS = BPM_W;
	localparam int DIV_CNT_W = 4;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'(DIV_STEPS - 1);

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_HOLD
	} div_state_t;

	typedef struct packed {
		logic valid;
		logic full;
	} fifo_status_t;

endpackage

>>> hw/rtl/thbr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thbr_front
// Holds the configuration and last beat time; accepts requests, qualifies
// peaks against threshold and refractory gap, and queues the elapsed time.
// ----------------------------------------------------------------------------
module thbr_front
	import thbr_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [TIME_W-1:0]          timestamp_ms,
	input  fifo_status_t               fifo_status,
	output logic                       push,
	output logic [TIME_W-1:0]          push_elapsed
);

	logic signed [SAMPLE_W-1:0] peak_threshold_q;
	logic [CFG_W-1:0]           min_gap_ms_q;
	logic [TIME_W-1:0]          last_beat_q;
	logic [TIME_W-1:0]          elapsed;
	logic                       is_peak;
	logic                       is_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_threshold_q <= PEAK_THRESHOLD_RST;
			min_gap_ms_q     <= MIN_GAP_MS_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_PEAK_THRESHOLD: peak_threshold_q <= $signed(cfg_data);
				REG_MIN_GAP_MS:     min_gap_ms_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign elapsed  = timestamp_ms - last_beat_q;
	assign is_peak  = sample > peak_threshold_q;
	assign is_beat  = is_peak && (elapsed > {{(TIME_W-CFG_W){1'b0}}, min_gap_ms_q});
	assign in_ready = !fifo_status.full;
	assign push     = in_valid && in_ready && is_beat;
	assign push_elapsed = elapsed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_beat_q <= '0;
		end else if (push) begin
			last_beat_q <= timestamp_ms;
		end
	end

endmodule

>>> hw/rtl/thbr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thbr_fifo
// Short queue of elapsed times between the front end and the divider.
// ----------------------------------------------------------------------------
module thbr_fifo
	import thbr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [TIME_W-1:0] push_data,
	input  logic              pop,
	output logic [TIME_W-1:0] pop_data,
	output fifo_status_t      status
);

	logic [TIME_W-1:0]     mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_data     = mem[rd_ptr_q];
	assign status.valid = (count_q != '0);
	assign status.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));

endmodule

>>> hw/rtl/thbr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thbr_div
// Radix-2 restoring divider for 60000 / elapsed, one quotient bit per cycle,
// with an output register towards the result channel.
// ----------------------------------------------------------------------------
module thbr_div
	import thbr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  fifo_status_t      fifo_status,
	input  logic [TIME_W-1:0] pop_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BPM_W-1:0]  beats_per_minute
);

	div_state_t           state_q;
	div_state_t           state_nxt;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TIME_W-1:0]    divisor_q;
	logic [BPM_W-1:0]     rem_q;
	logic [BPM_W-1:0]     quo_q;
	logic [BPM_W:0]       trial;
	logic [BPM_W:0]       diff;
	logic                 fits;
	logic                 slot_free;
	logic                 load_out;
	logic                 out_valid_q;
	logic [BPM_W-1:0]     bpm_q;

	assign slot_free = !out_valid_q || out_ready;
	assign trial     = {rem_q, quo_q[BPM_W-1]};
	assign fits      = {{(TIME_W-BPM_W-1){1'b0}}, trial} >= divisor_q;
	assign diff      = trial - divisor_q[BPM_W:0];

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			DIV_IDLE: begin
				if (fifo_status.valid) state_nxt = DIV_RUN;
			end
			DIV_RUN: begin
				if (cnt_q == DIV_LAST) state_nxt = DIV_HOLD;
			end
			DIV_HOLD: begin
				if (slot_free) state_nxt = DIV_IDLE;
			end
			default: state_nxt = DIV_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			DIV_IDLE: pop      = fifo_status.valid;
			DIV_RUN:  ;
			DIV_HOLD: load_out = slot_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= DIV_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (pop) begin
				cnt_q <= '0;
			end else if (state_q == DIV_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			divisor_q <= pop_data;
			rem_q     <= '0;
			quo_q     <= RATE_NUMERATOR;
		end else if (state_q == DIV_RUN) begin
			rem_q <= fits ? diff[BPM_W-1:0] : trial[BPM_W-1:0];
			quo_q <= {quo_q[BPM_W-2:0], fits};
		end
		if (load_out) begin
			bpm_q <= quo_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign beats_per_minute = bpm_q;

`ifndef SYNTHESIS
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DIV_RUN) |-> (divisor_q != '0))
		else $error("divider running on zero divisor");

	a_bpm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (bpm_q <= RATE_NUMERATOR))
		else $error("rate above numerator");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DIV_RUN && cnt_q == DIV_LAST) |=> (state_q == DIV_HOLD))
		else $error("divider overran its steps");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("finished rate not presented");
`endif

endmodule

>>> hw/rtl/threshold_heartbeat_rate_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_heartbeat_rate_detector
// Peak detector with refractory gap; emits 60000 / elapsed ms per beat.
// ----------------------------------------------------------------------------
// A request that is a beat has its elapsed time queued, divided, then registered out.
// Throughput: one request per cycle while the two-entry queue has room; beats
// drain one at a time through the 16-step divider, which pops only when idle.
// Reset: asynchronous; threshold 2000, gap 600 ms, last beat time 0, queue
// and output empty.
module threshold_heartbeat_rate_detector
	import thbr_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [TIME_W-1:0]          timestamp_ms,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [BPM_W-1:0]           beats_per_minute
);

	fifo_status_t      fifo_status;
	logic              push;
	logic [TIME_W-1:0] push_elapsed;
	logic              pop;
	logic [TIME_W-1:0] pop_data;

	thbr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.timestamp_ms (timestamp_ms),
		.fifo_status  (fifo_status),
		.push         (push),
		.push_elapsed (push_elapsed)
	);

	thbr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_elapsed),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (fifo_status)
	);

	thbr_div u_div (
		.clk              (clk),
		.arst_n           (arst_n),
		.fifo_status      (fifo_status),
		.pop_data         (pop_data),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.beats_per_minute (beats_per_minute)
	);

endmodule
